// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list engine modules.
// Each macro names the clock and the active-low reset that qualify it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define CLLE_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("list engine assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define CLLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine assertion failed");

`endif

// ===== rtl/core/clle_pkg.sv =====
`default_nettype none

package clle_pkg;

    // Default pool size; slot 0 is null and the last slot is never used.
    localparam int SLOT_COUNT_DEF = 64;

    // Fixed field widths.
    localparam int MODE_W = 2;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 6;
    localparam int ST_W   = 2;

    // Request kinds.
    localparam logic [MODE_W-1:0] MODE_INSERT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TRAVERSE = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Source of the link memory read address.
    typedef logic [1:0] rd_sel_t;
    localparam rd_sel_t RD_CUR  = 2'd0;
    localparam rd_sel_t RD_FREE = 2'd1;
    localparam rd_sel_t RD_HEAD = 2'd2;
    localparam rd_sel_t RD_LINK = 2'd3;

    // Address of a link write.
    typedef logic lw_addr_t;
    localparam lw_addr_t LWA_SLOT = 1'b0;
    localparam lw_addr_t LWA_CUR  = 1'b1;

    // Data of a link write.
    typedef logic [1:0] lw_data_t;
    localparam lw_data_t LWD_HEAD = 2'd0;
    localparam lw_data_t LWD_LINK = 2'd1;
    localparam lw_data_t LWD_SLOT = 2'd2;
    localparam lw_data_t LWD_FREE = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            req_ld;
        logic            cur_ld_head;
        logic            cur_ld_link;
        logic            step_clr;
        logic            step_inc;
        logic            rd_en;
        rd_sel_t         rd_sel;
        logic            byte_wr;
        logic            slot_ld_free;
        logic            slot_ld_head;
        logic            slot_ld_link;
        logic            free_ld_link;
        logic            free_ld_slot;
        logic            head_ld_slot;
        logic            head_ld_link;
        logic            lwr_en;
        lw_addr_t        lwr_addr_sel;
        lw_data_t        lwr_data_sel;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            out_ld;
        logic [ST_W-1:0] out_status;
        logic            out_elem;
        logic            out_last;
    } clle_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              pos_gt_cnt;
        logic              pos_ge_cnt;
        logic              pos_zero;
        logic              free_empty;
        logic              cnt_zero;
        logic              at_prev;
        logic              trav_last;
        logic              out_free;
    } clle_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/clle_datapath.sv =====
`default_nettype none
`include "assert_macros.svh"

module clle_datapath
    import clle_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire clle_cmd_t         cmd,
    output clle_sts_t              sts,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [BYTE_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ST_W-1:0]        status,
    output logic [CNT_W-1:0]       length,
    output logic [BYTE_W-1:0]      element,
    output logic                   element_valid,
    output logic                   last
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(SLOT_COUNT - 2);
    localparam logic [SW-1:0] LAST_CHAINED = SW'(SLOT_COUNT - 3);

    // Request fields.
    logic [MODE_W-1:0] mode_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [BYTE_W-1:0] val_reg;

    // Walk and bookkeeping registers.
    logic [SW-1:0]    cur_reg;
    logic [SW-1:0]    slot_reg;
    logic [CNT_W-1:0] step_reg;
    logic [SW-1:0]    free_head_reg;
    logic [SW-1:0]    list_head_reg;
    logic [CNT_W-1:0] count_reg;

    // Pool storage.
    logic [SW-1:0]     link_mem [SLOT_COUNT];
    logic [BYTE_W-1:0] byte_mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] link_vld_reg;
    logic [SW-1:0]     link_q_reg;
    logic              link_qv_reg;
    logic [SW-1:0]     link_qd_reg;
    logic [BYTE_W-1:0] byte_q_reg;

    // Output register.
    logic              out_valid_reg;
    logic [ST_W-1:0]   status_reg;
    logic [CNT_W-1:0]  length_reg;
    logic [BYTE_W-1:0] element_reg;
    logic              element_valid_reg;
    logic              last_reg;

    logic [SW-1:0] rd_link;
    logic [SW-1:0] rd_addr;
    logic [SW-1:0] rd_dflt;
    logic [SW-1:0] lwr_addr;
    logic [SW-1:0] lwr_data;
    logic          out_free;

    // An entry never written reads as its reset link.
    assign rd_link = link_qv_reg ? link_q_reg : link_qd_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_CUR:  rd_addr = cur_reg;
            RD_FREE: rd_addr = free_head_reg;
            RD_HEAD: rd_addr = list_head_reg;
            RD_LINK: rd_addr = rd_link;
            default: rd_addr = cur_reg;
        endcase
    end

    assign rd_dflt = (rd_addr != '0 && rd_addr <= LAST_CHAINED) ? rd_addr + SW'(1) : '0;

    assign lwr_addr = (cmd.lwr_addr_sel == LWA_CUR) ? cur_reg : slot_reg;

    always_comb
    begin
        case (cmd.lwr_data_sel)
            LWD_HEAD: lwr_data = list_head_reg;
            LWD_LINK: lwr_data = rd_link;
            LWD_SLOT: lwr_data = slot_reg;
            LWD_FREE: lwr_data = free_head_reg;
            default:  lwr_data = slot_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.lwr_en)
        begin
            link_mem[lwr_addr] <= lwr_data;
        end
        if (cmd.rd_en)
        begin
            link_q_reg <= link_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.byte_wr)
        begin
            byte_mem[free_head_reg] <= val_reg;
        end
        if (cmd.rd_en)
        begin
            byte_q_reg <= byte_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
            link_qv_reg  <= 1'b0;
            link_qd_reg  <= '0;
        end
        else
        begin
            if (cmd.lwr_en)
            begin
                link_vld_reg[lwr_addr] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                link_qv_reg <= link_vld_reg[rd_addr];
                link_qd_reg <= rd_dflt;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.req_ld)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            val_reg  <= value;
        end
        if (cmd.cur_ld_head)
        begin
            cur_reg <= list_head_reg;
        end
        else if (cmd.cur_ld_link)
        begin
            cur_reg <= rd_link;
        end
        if (cmd.slot_ld_free)
        begin
            slot_reg <= free_head_reg;
        end
        else if (cmd.slot_ld_head)
        begin
            slot_reg <= list_head_reg;
        end
        else if (cmd.slot_ld_link)
        begin
            slot_reg <= rd_link;
        end
        if (cmd.step_clr)
        begin
            step_reg <= '0;
        end
        else if (cmd.step_inc)
        begin
            step_reg <= step_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= SW'(1);
            list_head_reg <= '0;
            count_reg     <= '0;
        end
        else
        begin
            if (cmd.free_ld_link)
            begin
                free_head_reg <= rd_link;
            end
            else if (cmd.free_ld_slot)
            begin
                free_head_reg <= slot_reg;
            end
            if (cmd.head_ld_slot)
            begin
                list_head_reg <= slot_reg;
            end
            else if (cmd.head_ld_link)
            begin
                list_head_reg <= rd_link;
            end
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_ld)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_ld)
        begin
            status_reg        <= cmd.out_status;
            length_reg        <= count_reg;
            element_reg       <= cmd.out_elem ? byte_q_reg : '0;
            element_valid_reg <= cmd.out_elem;
            last_reg          <= cmd.out_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign length        = length_reg;
    assign element       = element_reg;
    assign element_valid = element_valid_reg;
    assign last          = last_reg;

    assign sts.mode       = mode_reg;
    assign sts.pos_gt_cnt = pos_reg > count_reg;
    assign sts.pos_ge_cnt = pos_reg >= count_reg;
    assign sts.pos_zero   = pos_reg == '0;
    assign sts.free_empty = free_head_reg == '0;
    assign sts.cnt_zero   = count_reg == '0;
    assign sts.at_prev    = step_reg == (pos_reg - POS_W'(1));
    assign sts.trav_last  = ({1'b0, step_reg} + (CNT_W+1)'(1)) == {1'b0, count_reg};
    assign sts.out_free   = out_free;

    `CLLE_ASSERT_ALWAYS(a_count_cap, clk, rst_n, count_reg <= CAP)
    `CLLE_ASSERT_ALWAYS(a_full_no_free, clk, rst_n, count_reg != CAP || free_head_reg == '0)
    `CLLE_ASSERT_ALWAYS(a_empty_no_head, clk, rst_n, count_reg != '0 || list_head_reg == '0)

endmodule

`default_nettype wire

// ===== rtl/core/clle_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"

module clle_ctrl
    import clle_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire clle_sts_t sts,
    output clle_cmd_t      cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DEC    = 5'd1;
    localparam logic [4:0] S_INS0   = 5'd2;
    localparam logic [4:0] S_INS1   = 5'd3;
    localparam logic [4:0] S_INSH   = 5'd4;
    localparam logic [4:0] S_WSTART = 5'd5;
    localparam logic [4:0] S_WALK   = 5'd6;
    localparam logic [4:0] S_IA0    = 5'd7;
    localparam logic [4:0] S_IA1    = 5'd8;
    localparam logic [4:0] S_IA2    = 5'd9;
    localparam logic [4:0] S_D0     = 5'd10;
    localparam logic [4:0] S_DH1    = 5'd11;
    localparam logic [4:0] S_DFREE  = 5'd12;
    localparam logic [4:0] S_DA0    = 5'd13;
    localparam logic [4:0] S_DA1    = 5'd14;
    localparam logic [4:0] S_DA2    = 5'd15;
    localparam logic [4:0] S_RES    = 5'd16;
    localparam logic [4:0] S_T0     = 5'd17;
    localparam logic [4:0] S_T1     = 5'd18;

    logic [4:0]      state_reg;
    logic [4:0]      state_next;
    logic [ST_W-1:0] res_status_reg;
    logic [ST_W-1:0] res_status_next;
    logic [4:0]      walk_done_state;

    assign in_ready = state_reg == S_IDLE;

    // Once the predecessor is found, insert and delete part ways.
    assign walk_done_state = (sts.mode == MODE_INSERT) ? S_IA0 : S_DA0;

    always_comb
    begin
        cmd             = '0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.req_ld = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.cur_ld_head = 1'b1;
                cmd.step_clr    = 1'b1;
                res_status_next = ST_OK;
                case (sts.mode)
                    MODE_INSERT:
                    begin
                        if (sts.pos_gt_cnt)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_RES;
                        end
                        else if (sts.free_empty)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_RES;
                        end
                        else
                        begin
                            state_next = S_INS0;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_RES;
                        end
                        else if (sts.pos_zero)
                        begin
                            state_next = S_D0;
                        end
                        else
                        begin
                            state_next = S_WSTART;
                        end
                    end
                    MODE_TRAVERSE:
                    begin
                        state_next = sts.cnt_zero ? S_RES : S_T0;
                    end
                    default:
                    begin
                        state_next = S_RES;
                    end
                endcase
            end
            S_INS0:
            begin
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = RD_FREE;
                cmd.byte_wr      = 1'b1;
                cmd.slot_ld_free = 1'b1;
                state_next       = S_INS1;
            end
            S_INS1:
            begin
                cmd.free_ld_link = 1'b1;
                state_next       = sts.pos_zero ? S_INSH : S_WSTART;
            end
            S_INSH:
            begin
                cmd.lwr_en       = 1'b1;
                cmd.lwr_addr_sel = LWA_SLOT;
                cmd.lwr_data_sel = LWD_HEAD;
                cmd.head_ld_slot = 1'b1;
                cmd.cnt_inc      = 1'b1;
                state_next       = S_RES;
            end
            S_WSTART:
            begin
                if (sts.at_prev)
                begin
                    state_next = walk_done_state;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_CUR;
                    cmd.step_inc = 1'b1;
                    state_next   = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.cur_ld_link = 1'b1;
                if (sts.at_prev)
                begin
                    state_next = walk_done_state;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_sel   = RD_LINK;
                    cmd.step_inc = 1'b1;
                end
            end
            S_IA0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = S_IA1;
            end
            S_IA1:
            begin
                cmd.lwr_en       = 1'b1;
                cmd.lwr_addr_sel = LWA_SLOT;
                cmd.lwr_data_sel = LWD_LINK;
                state_next       = S_IA2;
            end
            S_IA2:
            begin
                cmd.lwr_en       = 1'b1;
                cmd.lwr_addr_sel = LWA_CUR;
                cmd.lwr_data_sel = LWD_SLOT;
                cmd.cnt_inc      = 1'b1;
                state_next       = S_RES;
            end
            S_D0:
            begin
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = RD_HEAD;
                cmd.slot_ld_head = 1'b1;
                state_next       = S_DH1;
            end
            S_DH1:
            begin
                cmd.head_ld_link = 1'b1;
                state_next       = S_DFREE;
            end
            S_DFREE:
            begin
                cmd.lwr_en       = 1'b1;
                cmd.lwr_addr_sel = LWA_SLOT;
                cmd.lwr_data_sel = LWD_FREE;
                cmd.free_ld_slot = 1'b1;
                cmd.cnt_dec      = 1'b1;
                state_next       = S_RES;
            end
            S_DA0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_CUR;
                state_next = S_DA1;
            end
            S_DA1:
            begin
                cmd.slot_ld_link = 1'b1;
                cmd.rd_en        = 1'b1;
                cmd.rd_sel       = RD_LINK;
                state_next       = S_DA2;
            end
            S_DA2:
            begin
                cmd.lwr_en       = 1'b1;
                cmd.lwr_addr_sel = LWA_CUR;
                cmd.lwr_data_sel = LWD_LINK;
                state_next       = S_DFREE;
            end
            S_RES:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_status = res_status_reg;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_T0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HEAD;
                state_next = S_T1;
            end
            S_T1:
            begin
                if (sts.out_free)
                begin
                    cmd.out_ld     = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_elem   = 1'b1;
                    cmd.out_last   = sts.trav_last;
                    if (sts.trav_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en    = 1'b1;
                        cmd.rd_sel   = RD_LINK;
                        cmd.step_inc = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            res_status_reg <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
        end
    end

    `CLLE_ASSERT_NEXT(a_accept_decodes, clk, rst_n, in_valid && in_ready, state_reg == S_DEC)
    `CLLE_ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !cmd.out_ld || sts.out_free)

endmodule

`default_nettype wire

// ===== rtl/core/cursor_linked_list_engine.sv =====
// Linked list engine over a fixed pool of slots, with a chain of free slots.
// Input channel (in_valid, in_ready): one request per item, carrying mode
// (insert, delete, traverse), position and value. Output channel (out_valid,
// out_ready): result items with status, length after the request, element,
// element_valid and last. Insert and delete give exactly one result item;
// traverse gives one per list entry, or a single empty item for an empty list.
// Requests are handled one at a time: in_ready is high only while the
// controller waits for a request, and it rises again as soon as the final
// result item is in the output register, even if it has not yet been taken.
// Errors, unused modes and the traverse of an empty list go straight from
// decode to the result. Insert and delete at position 0 need no walk; at
// position p > 0 the controller first walks the link chain to the slot
// before p, one slot per cycle through the single read port of the link
// memory. Traverse offers one entry per cycle while the receiver takes
// them; a full pool holds 62 entries. When the receiver stalls, the
// result is held in the output register and the traverse walk pauses
// until it is taken. Reset empties the list and chains the free slots
// 1 to 62 in order; link entries never written read back as that reset
// chain, so no clearing pass is needed and a request can be accepted in
// the first cycle after reset.
`default_nettype none

module cursor_linked_list_engine
    import clle_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [MODE_W-1:0] mode,
    input  wire logic [POS_W-1:0]  position,
    input  wire logic [BYTE_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ST_W-1:0]        status,
    output logic [CNT_W-1:0]       length,
    output logic [BYTE_W-1:0]      element,
    output logic                   element_valid,
    output logic                   last
);

    // The controller sequences each request; the datapath holds the pool,
    // the chain heads, the entry count and the output register.
    clle_cmd_t cmd;
    clle_sts_t sts;

    clle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    clle_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .mode          (mode),
        .position      (position),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .length        (length),
        .element       (element),
        .element_valid (element_valid),
        .last          (last)
    );

endmodule

`default_nettype wire
